FILE: rtl/sbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbb_pkg;

  localparam int SEM_W     = 6;
  localparam int CAP_W     = 5;
  localparam int FILL_W    = 5;
  localparam int STATUS_W  = 3;
  localparam int BYTE_W    = 8;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int CALC_W    = 10;

  typedef logic signed [SEM_W-1:0] sem_t;

  localparam sem_t SEM_MAX = 6'sd31;
  localparam sem_t SEM_MIN = -6'sd32;

  // Register index of the capacity register, taken from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_PRODUCED = 3'd0,
    ST_CONSUMED = 3'd1,
    ST_BLOCKED  = 3'd2,
    ST_REQUEUED = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef struct packed {
    logic push;
    logic pop;
  } op_req_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } wq_stat_t;

  function automatic sem_t sem_dec(input sem_t s);
    sem_t r;
    r = (s == SEM_MIN) ? s : sem_t'(s - 6'sd1);
    return r;
  endfunction

  function automatic sem_t sem_inc(input sem_t s);
    sem_t r;
    r = (s == SEM_MAX) ? s : sem_t'(s + 6'sd1);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sbb_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface sbb_req_if import sbb_pkg::*; #(
  parameter int ID_BITS = 8
);
  logic               valid;
  logic               ready;
  logic               mode;
  logic [ID_BITS-1:0] proc_id;
  logic [BYTE_W-1:0]  item_byte;
  logic               resumed;

  modport source (output valid, mode, proc_id, item_byte, resumed, input ready);
  modport sink   (input valid, mode, proc_id, item_byte, resumed, output ready);
endinterface

interface sbb_rsp_if import sbb_pkg::*; #(
  parameter int ID_BITS = 8
);
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_BITS-1:0]  served_id;
  logic [BYTE_W-1:0]   taken_byte;
  logic                wake_valid;
  logic [ID_BITS-1:0]  wake_id;
  logic [FILL_W-1:0]   fill_level;

  modport source (output valid, status, served_id, taken_byte, wake_valid, wake_id,
                  fill_level, input ready);
  modport sink   (input valid, status, served_id, taken_byte, wake_valid, wake_id,
                  fill_level, output ready);
endinterface

`default_nettype wire

FILE: rtl/sbb_wait_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module sbb_wait_fifo import sbb_pkg::*; #(
  parameter int WAIT_DEPTH = 16,
  parameter int ID_BITS    = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire op_req_t            req_i,
  input  wire logic [ID_BITS-1:0] push_id_i,
  output wq_stat_t                stat_o,
  output logic      [ID_BITS-1:0] head_id_o
);

  localparam int WI = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int WC = $clog2(WAIT_DEPTH + 1);
  localparam logic [WI-1:0] LAST = WI'(WAIT_DEPTH - 1);
  localparam logic [WC-1:0] FULL_COUNT = WC'(WAIT_DEPTH);

  logic [ID_BITS-1:0] ids_q [WAIT_DEPTH];
  logic [WI-1:0]      head_q, head_d, tail_q, tail_d;
  logic [WC-1:0]      count_q, count_d;
  logic               do_push, do_pop;

  assign stat_o.full     = (count_q == FULL_COUNT);
  assign stat_o.nonempty = (count_q != '0);
  assign head_id_o       = ids_q[head_q];

  assign do_push = req_i.push && !stat_o.full;
  assign do_pop  = req_i.pop && stat_o.nonempty;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (do_push) begin
      tail_d = (tail_q == LAST) ? '0 : WI'(tail_q + 1'b1);
    end
    if (do_pop) begin
      head_d = (head_q == LAST) ? '0 : WI'(head_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = WC'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = WC'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ids_q[tail_q] <= push_id_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sbb_item_stack.sv
`timescale 1ns / 1ps
`default_nettype none

module sbb_item_stack import sbb_pkg::*; #(
  parameter int BUF_DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire op_req_t                          req_i,
  input  wire logic [BYTE_W-1:0]                push_byte_i,
  output logic      [$clog2(BUF_DEPTH+1)-1:0]   count_o,
  output logic      [BYTE_W-1:0]                top_byte_o
);

  localparam int BI = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CW = $clog2(BUF_DEPTH + 1);

  logic [BYTE_W-1:0] items_q [BUF_DEPTH];
  logic [CW-1:0]     count_q, count_d, top_idx;

  assign top_idx    = CW'(count_q - 1'b1);
  assign top_byte_o = items_q[top_idx[BI-1:0]];
  assign count_o    = count_q;

  always_comb begin
    count_d = count_q;
    if (req_i.push) begin
      count_d = CW'(count_q + 1'b1);
    end else if (req_i.pop) begin
      count_d = CW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      items_q[count_q[BI-1:0]] <= push_byte_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/semaphore_bounded_buffer_top.sv
// A request accepted into the input register has its result loaded into the result
// register once that register is empty or its current result is being taken.
// Throughput: one request per cycle while results are taken; the semaphore, stack and
// queue updates all complete in the single step between the input and result registers.
// Reset: asynchronous, active low; clears the stack count, both queues, the
// semaphores (empty to the reset capacity, BUF_DEPTH but at most 16) and all valid flags.
`timescale 1ns / 1ps
`default_nettype none

module semaphore_bounded_buffer_top import sbb_pkg::*; #(
  parameter int BUF_DEPTH  = 16,
  parameter int WAIT_DEPTH = 16,
  parameter int ID_BITS    = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  sbb_req_if.sink                 req_i,
  sbb_rsp_if.source               rsp_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam logic [CAP_W-1:0] CAP_RESET = (BUF_DEPTH < 16) ? CAP_W'(BUF_DEPTH) : 5'd16;
  localparam logic [CALC_W-1:0] DEPTH_C = CALC_W'(BUF_DEPTH);

  // Input register.
  logic               s1_valid_q;
  logic               s1_mode_q;
  logic [ID_BITS-1:0] s1_id_q;
  logic [BYTE_W-1:0]  s1_byte_q;
  logic               s1_resumed_q;
  logic               fire;

  // Control state.
  logic [CAP_W-1:0] cap_q, cap_d;
  sem_t             empty_q, empty_d, full_q, full_d;
  logic             cfg_wr;

  // Result register.
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [ID_BITS-1:0]  out_id_q;
  logic [BYTE_W-1:0]   out_taken_q;
  logic                out_wake_q;
  logic [ID_BITS-1:0]  out_wake_id_q;
  logic [FILL_W-1:0]   out_fill_q;

  // Submodule signals.
  op_req_t            stk_req, pq_req, cq_req;
  wq_stat_t           pq_stat, cq_stat;
  logic [ID_BITS-1:0] pq_head, cq_head;
  logic [CW-1:0]      count;
  logic [BYTE_W-1:0]  top_byte;

  // Step logic.
  logic               consumer;
  sem_t               own_sem, own_dn, other_sem, other_up;
  logic               blocked, can_push, can_pop, work_ok, own_full, wake;
  logic               other_nonempty;
  status_e            status;
  logic [CW-1:0]      count_after;
  logic [ID_BITS-1:0] other_head;

  // Configuration values.
  logic [CAP_W-1:0]         wcap;
  logic signed [CALC_W-1:0] cfg_e;
  sem_t                     cfg_empty, cfg_full;

  assign fire         = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready  = !s1_valid_q || fire;

  assign consumer  = s1_mode_q;
  assign own_sem   = consumer ? full_q : empty_q;
  assign other_sem = consumer ? empty_q : full_q;
  assign own_dn    = s1_resumed_q ? own_sem : sem_dec(own_sem);
  assign other_up  = sem_inc(other_sem);
  assign blocked   = !s1_resumed_q && own_dn[SEM_W-1];

  assign can_push = (CALC_W'(count) < CALC_W'(cap_q)) && (CALC_W'(count) < DEPTH_C);
  assign can_pop  = (count != '0);
  assign work_ok  = consumer ? can_pop : can_push;
  assign own_full = consumer ? cq_stat.full : pq_stat.full;

  assign other_nonempty = consumer ? pq_stat.nonempty : cq_stat.nonempty;
  assign other_head     = consumer ? pq_head : cq_head;
  assign wake = !blocked && (other_up[SEM_W-1] || (other_up == '0)) && other_nonempty;

  always_comb begin
    if (blocked) begin
      status = own_full ? ST_OVERFLOW : ST_BLOCKED;
    end else if (work_ok) begin
      status = consumer ? ST_CONSUMED : ST_PRODUCED;
    end else begin
      status = own_full ? ST_OVERFLOW : ST_REQUEUED;
    end
  end

  assign stk_req.push = fire && !consumer && !blocked && can_push;
  assign stk_req.pop  = fire && consumer && !blocked && can_pop;
  assign pq_req.push  = fire && !consumer && !(work_ok && !blocked);
  assign pq_req.pop   = fire && consumer && wake;
  assign cq_req.push  = fire && consumer && !(work_ok && !blocked);
  assign cq_req.pop   = fire && !consumer && wake;

  always_comb begin
    count_after = count;
    if (stk_req.push) begin
      count_after = CW'(count + 1'b1);
    end else if (stk_req.pop) begin
      count_after = CW'(count - 1'b1);
    end
  end

  // A capacity write clamps to 1..BUF_DEPTH and rebuilds both semaphores.
  always_comb begin
    wcap = pwdata[CAP_W-1:0];
    if (wcap == '0) begin
      wcap = CAP_W'(1);
    end else if (CALC_W'(wcap) > DEPTH_C) begin
      wcap = CAP_W'(BUF_DEPTH);
    end
    cfg_e = $signed(CALC_W'(wcap)) - $signed(CALC_W'(count));
    if (cfg_e > CALC_W'(SEM_MAX)) begin
      cfg_empty = SEM_MAX;
    end else if (cfg_e < CALC_W'(SEM_MIN)) begin
      cfg_empty = SEM_MIN;
    end else begin
      cfg_empty = cfg_e[SEM_W-1:0];
    end
    cfg_full = (CALC_W'(count) > CALC_W'(SEM_MAX)) ? SEM_MAX : sem_t'(count);
  end

  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_q) : '0;

  always_comb begin
    cap_d   = cap_q;
    empty_d = empty_q;
    full_d  = full_q;
    if (cfg_wr) begin
      cap_d   = wcap;
      empty_d = cfg_empty;
      full_d  = cfg_full;
    end else if (fire) begin
      if (consumer) begin
        full_d = own_dn;
        if (!blocked) begin
          empty_d = other_up;
        end
      end else begin
        empty_d = own_dn;
        if (!blocked) begin
          full_d = other_up;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      empty_q     <= sem_t'(CAP_RESET);
      full_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q   <= cap_d;
      empty_q <= empty_d;
      full_q  <= full_d;
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_mode_q    <= req_i.mode;
      s1_id_q      <= req_i.proc_id;
      s1_byte_q    <= req_i.item_byte;
      s1_resumed_q <= req_i.resumed;
    end
    if (fire) begin
      out_status_q  <= status;
      out_id_q      <= s1_id_q;
      out_taken_q   <= stk_req.pop ? top_byte : '0;
      out_wake_q    <= wake;
      out_wake_id_q <= wake ? other_head : '0;
      out_fill_q    <= FILL_W'(count_after);
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.served_id  = out_id_q;
  assign rsp_o.taken_byte = out_taken_q;
  assign rsp_o.wake_valid = out_wake_q;
  assign rsp_o.wake_id    = out_wake_id_q;
  assign rsp_o.fill_level = out_fill_q;

  sbb_item_stack #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (stk_req),
    .push_byte_i (s1_byte_q),
    .count_o     (count),
    .top_byte_o  (top_byte)
  );

  sbb_wait_fifo #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_prod_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (pq_req),
    .push_id_i (s1_id_q),
    .stat_o    (pq_stat),
    .head_id_o (pq_head)
  );

  sbb_wait_fifo #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_cons_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (cq_req),
    .push_id_i (s1_id_q),
    .stat_o    (cq_stat),
    .head_id_o (cq_head)
  );

endmodule

`default_nettype wire

FILE: sim/tb_semaphore_bounded_buffer_top.sv
`timescale 1ns / 1ps

module tb_semaphore_bounded_buffer_top;
  import sbb_pkg::*;

  localparam int BUF_DEPTH   = 16;
  localparam int WAIT_DEPTH  = 16;
  localparam int ID_BITS     = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int STRESS_RUN  = 36;
  localparam int PHASE_ITEMS = 125;
  localparam int DIR_N       = 24;

  localparam logic MODE_PROD = 1'b0;
  localparam logic MODE_CONS = 1'b1;

  localparam logic [PADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

  typedef struct packed {
    status_e            status;
    logic [ID_BITS-1:0] served_id;
    logic [BYTE_W-1:0]  taken_byte;
    logic               wake_valid;
    logic [ID_BITS-1:0] wake_id;
    logic [FILL_W-1:0]  fill_level;
  } sched_result_t;

  typedef struct packed {
    logic               cfg;
    logic [31:0]        cfg_word;
    logic               kind;
    logic [ID_BITS-1:0] pid;
    logic [BYTE_W-1:0]  val;
    logic               res;
    logic               typed;
    sched_result_t      want;
  } dir_row_t;

  typedef struct packed {
    logic               kind;
    logic [ID_BITS-1:0] pid;
  } waiter_t;

  localparam sched_result_t NO_RES = '0;

  // Rows hold either a capacity write or one request; the first four carry their result.
  localparam dir_row_t DIRECTED [DIR_N] = '{
    '{1'b0, 32'd0, MODE_CONS, 8'h00, 8'h00, 1'b0, 1'b1,
      '{ST_BLOCKED, 8'h00, 8'h00, 1'b0, 8'h00, 5'd0}},
    '{1'b0, 32'd0, MODE_PROD, 8'hFF, 8'hFF, 1'b0, 1'b1,
      '{ST_PRODUCED, 8'hFF, 8'h00, 1'b1, 8'h00, 5'd1}},
    '{1'b0, 32'd0, MODE_CONS, 8'h00, 8'h00, 1'b1, 1'b1,
      '{ST_CONSUMED, 8'h00, 8'hFF, 1'b0, 8'h00, 5'd0}},
    '{1'b0, 32'd0, MODE_CONS, 8'h5A, 8'hC3, 1'b1, 1'b1,
      '{ST_REQUEUED, 8'h5A, 8'h00, 1'b0, 8'h00, 5'd0}},
    '{1'b1, 32'h0000_0000, MODE_PROD, 8'h00, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b0, 32'd0, MODE_PROD, 8'h01, 8'hA5, 1'b0, 1'b0, NO_RES},
    '{1'b0, 32'd0, MODE_PROD, 8'h02, 8'h5A, 1'b0, 1'b0, NO_RES},
    '{1'b0, 32'd0, MODE_PROD, 8'h03, 8'h00, 1'b1, 1'b0, NO_RES},
    '{1'b0, 32'd0, MODE_CONS, 8'h04, 8'hFF, 1'b0, 1'b0, NO_RES},
    '{1'b0, 32'd0, MODE_PROD, 8'h02, 8'h3C, 1'b1, 1'b0, NO_RES},
    '{1'b1, 32'h0000_001F, MODE_PROD, 8'h00, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b0, 32'd0, MODE_PROD, 8'h10, 8'h11, 1'b0, 1'b0, NO_RES},
    '{1'b0, 32'd0, MODE_PROD, 8'h11, 8'h22, 1'b0, 1'b0, NO_RES},
    '{1'b0, 32'd0, MODE_PROD, 8'h12, 8'h33, 1'b0, 1'b0, NO_RES},
    '{1'b1, 32'h0000_0002, MODE_PROD, 8'h00, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b0, 32'd0, MODE_PROD, 8'h13, 8'h44, 1'b0, 1'b0, NO_RES},
    '{1'b0, 32'd0, MODE_PROD, 8'h14, 8'h55, 1'b1, 1'b0, NO_RES},
    '{1'b0, 32'd0, MODE_CONS, 8'h20, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b0, 32'd0, MODE_CONS, 8'h21, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b0, 32'd0, MODE_CONS, 8'h22, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b0, 32'd0, MODE_CONS, 8'h23, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b0, 32'd0, MODE_CONS, 8'h24, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b1, 32'h0000_0010, MODE_PROD, 8'h00, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b0, 32'd0, MODE_PROD, 8'h80, 8'h80, 1'b0, 1'b0, NO_RES}
  };

  localparam int PHASE_CAP [8] = '{16, 1, 4, 16, 2, 8, 1, 16};

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  sbb_req_if #(.ID_BITS(ID_BITS)) req_if ();
  sbb_rsp_if #(.ID_BITS(ID_BITS)) rsp_if ();

  semaphore_bounded_buffer_top #(
    .BUF_DEPTH (BUF_DEPTH),
    .WAIT_DEPTH(WAIT_DEPTH),
    .ID_BITS   (ID_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Scheduler state as the block should hold it.
  int                 cap_q = BUF_DEPTH;
  int                 fill_cnt = 0;
  logic [BYTE_W-1:0]  stack_mem [BUF_DEPTH];
  sem_t               empty_s = sem_t'(BUF_DEPTH);
  sem_t               full_s = '0;
  logic [ID_BITS-1:0] prod_wait [$];
  logic [ID_BITS-1:0] cons_wait [$];

  sched_result_t      due_results [$];
  waiter_t            wake_list [$];

  int  tx_idle_pct = 0;
  int  rx_stall_pct = 0;
  bit  hold_pending = 1'b0;
  int  err_cnt = 0;
  int  req_cnt = 0;
  int  rsp_cnt = 0;
  int  cfg_cnt = 0;
  int  wake_cnt = 0;
  int  status_seen [5] = '{0, 0, 0, 0, 0};
  int  quiet_cycles = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic sem_t sem_sat(input sem_t s, input bit up);
    int v;
    v = int'(s) + (up ? 1 : -1);
    if (v > int'(SEM_MAX)) v = int'(SEM_MAX);
    if (v < int'(SEM_MIN)) v = int'(SEM_MIN);
    return sem_t'(v);
  endfunction

  function automatic bit park(input logic kind, input logic [ID_BITS-1:0] pid);
    if (kind == MODE_CONS) begin
      if (cons_wait.size() >= WAIT_DEPTH) return 1'b0;
      cons_wait.push_back(pid);
    end else begin
      if (prod_wait.size() >= WAIT_DEPTH) return 1'b0;
      prod_wait.push_back(pid);
    end
    return 1'b1;
  endfunction

  function automatic sched_result_t sched_step(input logic kind, input logic [ID_BITS-1:0] pid,
                                               input logic [BYTE_W-1:0] val, input logic res);
    sched_result_t r;
    bit            is_cons;
    sem_t          own;
    r = '0;
    is_cons = (kind == MODE_CONS);
    r.served_id = pid;
    if (!res) begin
      if (is_cons) full_s = sem_sat(full_s, 1'b0);
      else empty_s = sem_sat(empty_s, 1'b0);
    end
    own = is_cons ? full_s : empty_s;
    if (!res && own < 0) begin
      r.status = park(kind, pid) ? ST_BLOCKED : ST_OVERFLOW;
    end else begin
      if (!is_cons && fill_cnt < cap_q) begin
        stack_mem[fill_cnt] = val;
        fill_cnt++;
        r.status = ST_PRODUCED;
      end else if (is_cons && fill_cnt > 0) begin
        fill_cnt--;
        r.taken_byte = stack_mem[fill_cnt];
        r.status = ST_CONSUMED;
      end else begin
        r.status = park(kind, pid) ? ST_REQUEUED : ST_OVERFLOW;
      end
      if (is_cons) begin
        empty_s = sem_sat(empty_s, 1'b1);
        if (empty_s <= 0 && prod_wait.size() != 0) begin
          r.wake_valid = 1'b1;
          r.wake_id = prod_wait.pop_front();
        end
      end else begin
        full_s = sem_sat(full_s, 1'b1);
        if (full_s <= 0 && cons_wait.size() != 0) begin
          r.wake_valid = 1'b1;
          r.wake_id = cons_wait.pop_front();
        end
      end
    end
    r.fill_level = FILL_W'(fill_cnt);
    return r;
  endfunction

  task automatic flag_error(input string msg);
    if (err_cnt < 10) $display("ERROR: %s", msg);
    err_cnt++;
  endtask

  task automatic dispatch(input logic kind, input logic [ID_BITS-1:0] pid,
                          input logic [BYTE_W-1:0] val, input logic res,
                          input logic typed, input sched_result_t want);
    sched_result_t pred;
    waiter_t       w;
    req_if.valid     <= 1'b1;
    req_if.mode      <= kind;
    req_if.proc_id   <= pid;
    req_if.item_byte <= val;
    req_if.resumed   <= res;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pred = sched_step(kind, pid, val, res);
    due_results.push_back(typed ? want : pred);
    if (pred.wake_valid) begin
      w.kind = ~kind;
      w.pid = pred.wake_id;
      wake_list.push_back(w);
    end
    req_cnt++;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [31:0] word);
    int lim;
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    lim = int'(word[CAP_W-1:0]);
    if (lim == 0) lim = 1;
    if (lim > BUF_DEPTH) lim = BUF_DEPTH;
    cap_q = lim;
    empty_s = sem_t'(cap_q - fill_cnt);
    full_s = sem_t'(fill_cnt);
    cfg_cnt++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // The receiver stalls at random, and on request holds off for a long stretch.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      rsp_if.ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    sched_result_t want;
    string         exp_s;
    string         got_s;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      rsp_cnt++;
      if (rsp_if.status <= 3'd4) status_seen[rsp_if.status]++;
      if (rsp_if.wake_valid) wake_cnt++;
      if (due_results.size() == 0) begin
        flag_error($sformatf("result for id %02h with no request awaiting it",
                             rsp_if.served_id));
      end else begin
        want = due_results.pop_front();
        if (rsp_if.status !== want.status || rsp_if.served_id !== want.served_id ||
            rsp_if.taken_byte !== want.taken_byte || rsp_if.wake_valid !== want.wake_valid ||
            rsp_if.wake_id !== want.wake_id || rsp_if.fill_level !== want.fill_level) begin
          exp_s = $sformatf("st=%0d id=%02h byte=%02h wake=%0b/%02h fill=%0d",
                            want.status, want.served_id, want.taken_byte,
                            want.wake_valid, want.wake_id, want.fill_level);
          got_s = $sformatf("st=%0d id=%02h byte=%02h wake=%0b/%02h fill=%0d",
                            rsp_if.status, rsp_if.served_id, rsp_if.taken_byte,
                            rsp_if.wake_valid, rsp_if.wake_id, rsp_if.fill_level);
          flag_error($sformatf("result %0d: expected %s, got %s", rsp_cnt, exp_s, got_s));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles.", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    waiter_t w;
    int      pick;
    logic    kind;
    req_if.valid     = 1'b0;
    req_if.mode      = MODE_PROD;
    req_if.proc_id   = '0;
    req_if.item_byte = '0;
    req_if.resumed   = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 20;
    rx_stall_pct = 20;
    for (int i = 0; i < DIR_N; i++) begin
      if (DIRECTED[i].cfg) set_capacity(DIRECTED[i].cfg_word);
      else dispatch(DIRECTED[i].kind, DIRECTED[i].pid, DIRECTED[i].val, DIRECTED[i].res,
                    DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Long one-sided runs drive both semaphores to their limits and fill the wait queues.
    for (int s = 0; s < 4; s++) begin
      set_capacity(s == 0 ? 32'd1 : 32'd16);
      kind = (s == 1 || s == 2) ? MODE_CONS : MODE_PROD;
      for (int n = 0; n < STRESS_RUN; n++)
        dispatch(kind, ID_BITS'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                 1'(s % 2), 1'b0, NO_RES);
    end

    for (int ph = 0; ph < 8; ph++) begin
      set_capacity(($urandom() & 32'hFFFF_FFE0) | 32'(PHASE_CAP[ph]));
      tx_idle_pct = (ph % 4 == 1) ? 52 : (ph % 4 == 3) ? 38 : 0;
      rx_stall_pct = (ph % 4 == 2) ? 52 : (ph % 4 == 3) ? 38 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 40 && (ph == 0 || ph == 4)) hold_pending = 1'b1;
        pick = $urandom_range(99);
        if (pick < 8) begin
          dispatch(1'($urandom_range(1)), ID_BITS'($urandom_range(255)),
                   BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, NO_RES);
        end else if (pick < 55 && wake_list.size() != 0) begin
          w = wake_list.pop_front();
          dispatch(w.kind, w.pid, BYTE_W'($urandom_range(255)), 1'b1, 1'b0, NO_RES);
        end else begin
          dispatch(1'($urandom_range(1)), ID_BITS'($urandom_range(255)),
                   BYTE_W'($urandom_range(255)), 1'b0, 1'b0, NO_RES);
        end
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (due_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", due_results.size()));
    $display("Run covered %0d requests, %0d results, %0d wakes and %0d capacity writes.",
             req_cnt, rsp_cnt, wake_cnt, cfg_cnt);
    $display("Statuses: produced %0d, consumed %0d, blocked %0d, requeued %0d, overflow %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
